// ===== design/mks_pkg.sv =====
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants and decode functions for the keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT   = 2'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd500;
    localparam logic [CFG_W-1:0] SETTLE_RST   = 16'd100;
    localparam logic [CFG_W-1:0] GAP_RST      = 16'd5;

    localparam logic [3:0] LINES_ALL_HIGH = 4'hf;

    localparam logic [7:0] HI_CODES [4] = '{8'h70, 8'hb0, 8'hd0, 8'he0};
    localparam logic [7:0] LO_CODES [4] = '{8'h07, 8'h0b, 8'h0d, 8'h0e};

    localparam logic [7:0] KEY_BYTES [16] = '{
        8'd126, 8'd190, 8'd222, 8'd238, 8'd125, 8'd189, 8'd221, 8'd237,
        8'd123, 8'd187, 8'd219, 8'd235, 8'd119, 8'd183, 8'd215, 8'd231
    };
    localparam logic [3:0] KEY_NUMS [16] = '{
        4'd10, 4'd11, 4'd12, 4'd15, 4'd3, 4'd6, 4'd9, 4'd14,
        4'd2,  4'd5,  4'd8,  4'd0,  4'd1, 4'd4, 4'd7, 4'd13
    };

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_DEBOUNCE = 6'b000010,
        PH_SETTLE   = 6'b000100,
        PH_RELEASE1 = 6'b001000,
        PH_GAP      = 6'b010000,
        PH_RELEASE2 = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] settle_ticks;
        logic [CFG_W-1:0] release_gap_ticks;
        logic             layout_swap;
    } t_cfg;

    typedef struct packed {
        logic       cols_driven_high_side;
        logic       key_valid;
        logic [3:0] key_code;
        logic       key_unknown;
    } t_result;

    // code of the lowest-numbered low line, zero when all are high
    function automatic logic [7:0] line_code(logic [3:0] lines, logic upper);
        logic [7:0] code;
        code = 8'h00;
        for (int i = 3; i >= 0; i--) begin
            if (!lines[i]) begin
                code = upper ? HI_CODES[i] : LO_CODES[i];
            end
        end
        return code;
    endfunction

endpackage

// ===== design/mks_in_if.sv =====
// ----------------------------------------------------------------------------
// mks_in_if
// Input channel: one word of sampled row and column lines per tick.
// ----------------------------------------------------------------------------
interface mks_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_lines;
    logic [3:0] col_lines;

    modport source (output valid, output row_lines, output col_lines, input ready);
    modport sink   (input valid, input row_lines, input col_lines, output ready);
endinterface

// ===== design/mks_out_if.sv =====
// ----------------------------------------------------------------------------
// mks_out_if
// Output channel: drive side and decoded key for each tick.
// ----------------------------------------------------------------------------
interface mks_out_if;
    logic       valid;
    logic       ready;
    logic       cols_driven_high_side;
    logic       key_valid;
    logic [3:0] key_code;
    logic       key_unknown;

    modport source (output valid, output cols_driven_high_side, output key_valid,
                    output key_code, output key_unknown, input ready);
    modport sink   (input valid, input cols_driven_high_side, input key_valid,
                    input key_code, input key_unknown, output ready);
endinterface

// ===== design/mks_key_decode.sv =====
// ----------------------------------------------------------------------------
// mks_key_decode
// Maps the combined row/column byte to a key number via the fixed table.
// ----------------------------------------------------------------------------
module mks_key_decode
    import mks_pkg::*;
(
    input  logic [7:0] i_byte,
    output logic [3:0] o_code,
    output logic       o_unknown
);

    // table bytes are distinct, so at most one entry hits
    always_comb begin
        o_code    = 4'd0;
        o_unknown = 1'b1;
        for (int k = 0; k < 16; k++) begin
            if (KEY_BYTES[k] == i_byte) begin
                o_code    = KEY_NUMS[k];
                o_unknown = 1'b0;
            end
        end
    end

endmodule

// ===== design/mks_ctrl.sv =====
// ----------------------------------------------------------------------------
// mks_ctrl
// Scan sequencer: phase register, wait timer and latched row code.
// ----------------------------------------------------------------------------
module mks_ctrl
    import mks_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [3:0] i_rows,
    input  logic [3:0] i_cols,
    input  t_cfg       i_cfg,
    output t_result    o_res
);

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_wait,  n_wait;
    logic [7:0]             r_row_code, n_row_code;

    logic       rows_upper;
    logic       wait_zero;
    logic [7:0] combined;
    logic [3:0] dec_code;
    logic       dec_unknown;

    // saturate a register value into the timer
    function automatic logic [TIMER_WIDTH-1:0] timer_load(logic [CFG_W-1:0] v);
        logic [32:0] ext;
        ext = 33'(v);
        return (ext > TIMER_MAX) ? TIMER_MAX[TIMER_WIDTH-1:0] : ext[TIMER_WIDTH-1:0];
    endfunction

    assign rows_upper = !i_cfg.layout_swap;
    assign wait_zero  = (r_wait == '0);
    assign combined   = r_row_code | line_code(i_cols, !rows_upper);

    mks_key_decode u_decode (
        .i_byte    (combined),
        .o_code    (dec_code),
        .o_unknown (dec_unknown)
    );

    always_comb begin
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_row_code = r_row_code;
        o_res      = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_rows != LINES_ALL_HIGH) begin
                    n_wait  = timer_load(i_cfg.debounce_ticks);
                    n_phase = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (!wait_zero) begin
                    n_wait = r_wait - 1'b1;
                end else if (i_rows != LINES_ALL_HIGH) begin
                    n_row_code = line_code(i_rows, rows_upper);
                    n_wait     = timer_load(i_cfg.settle_ticks);
                    n_phase    = PH_SETTLE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_SETTLE: begin
                o_res.cols_driven_high_side = 1'b1;
                if (!wait_zero) begin
                    n_wait = r_wait - 1'b1;
                end else begin
                    o_res.key_valid   = 1'b1;
                    o_res.key_code    = dec_code;
                    o_res.key_unknown = dec_unknown;
                    n_phase           = PH_RELEASE1;
                end
            end
            PH_RELEASE1: begin
                o_res.cols_driven_high_side = 1'b1;
                if (i_cols == LINES_ALL_HIGH) begin
                    n_wait  = timer_load(i_cfg.release_gap_ticks);
                    n_phase = PH_GAP;
                end
            end
            PH_GAP: begin
                o_res.cols_driven_high_side = 1'b1;
                if (!wait_zero) begin
                    n_wait = r_wait - 1'b1;
                end else begin
                    n_phase = (i_cols == LINES_ALL_HIGH) ? PH_IDLE : PH_RELEASE2;
                end
            end
            PH_RELEASE2: begin
                o_res.cols_driven_high_side = 1'b1;
                if (i_cols == LINES_ALL_HIGH) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_wait     <= '0;
            r_row_code <= 8'h00;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_wait     <= n_wait;
            r_row_code <= n_row_code;
        end
    end

`ifndef NO_ASSERTIONS
    a_unknown_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.key_unknown |-> o_res.key_valid)
        else $error("unknown flag without key_valid");

    a_valid_on_col_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.key_valid |-> (o_res.cols_driven_high_side && r_phase == PH_SETTLE))
        else $error("key reported outside settle check");

    a_settle_to_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_SETTLE && wait_zero) |=> (r_phase == PH_RELEASE1))
        else $error("settle check did not move to release wait");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_phase) && $stable(r_wait) && $stable(r_row_code)))
        else $error("scan state moved without a tick");
`endif

endmodule

// ===== design/matrix_keypad_scanner.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// 4x4 line-reversal keypad scanner, one word per timer tick.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  i_in     in   valid / ready    row_lines[3:0], col_lines[3:0]
//  o_out    out  valid / ready    cols_driven_high_side, key_valid,
//                                 key_code[3:0], key_unknown
//  cfg      in   i_cfg_we         i_cfg_idx[1:0], i_cfg_wdata[15:0]
//
//  One word in, one word out; a new word is taken every cycle unless the output is stalled.
//  Each word passes through the input register, then the scan step into the
//  output register.
//  Reset (synchronous, active low) empties both registers, puts the scanner
//  in idle and loads the register defaults (500 / 100 / 5 / 0).
//  A stalled output holds its word; the input register fills behind it and
//  ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner
    import mks_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mks_in_if.sink               i_in,
    mks_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // configuration registers
    t_cfg r_cfg;

    // input stage
    logic       r_in_valid;
    logic [3:0] r_rows;
    logic [3:0] r_cols;

    // output stage
    logic    r_out_valid;
    t_result r_out;

    logic    step;      // the buffered word is scanned this cycle
    t_result res;

    // a word moves on when the output register is free or being drained
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks    <= DEBOUNCE_RST;
            r_cfg.settle_ticks      <= SETTLE_RST;
            r_cfg.release_gap_ticks <= GAP_RST;
            r_cfg.layout_swap       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEBOUNCE: r_cfg.debounce_ticks    <= i_cfg_wdata;
                REG_SETTLE:   r_cfg.settle_ticks      <= i_cfg_wdata;
                REG_GAP:      r_cfg.release_gap_ticks <= i_cfg_wdata;
                REG_LAYOUT:   r_cfg.layout_swap       <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_rows <= i_in.row_lines;
            r_cols <= i_in.col_lines;
        end
    end

    // scan sequencer; state advances only on a stepped word
    mks_ctrl #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_rows  (r_rows),
        .i_cols  (r_cols),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out.valid                 = r_out_valid;
    assign o_out.cols_driven_high_side = r_out.cols_driven_high_side;
    assign o_out.key_valid             = r_out.key_valid;
    assign o_out.key_code              = r_out.key_code;
    assign o_out.key_unknown           = r_out.key_unknown;

endmodule
